>>> design/pso_pkg.sv
// Shared constants, types and helpers of the particle swarm update block.
package pso_pkg;

	// Sizing
	localparam int DIMS      = 32;
	localparam int FRAC_BITS = 16;
	localparam int RFRAC_BITS = 16;
	localparam int ADDR_W    = (DIMS > 1) ? $clog2(DIMS) : 1;
	localparam int DIM_W     = 5;
	localparam int VAL_W     = 32;
	localparam int LIMIT_W   = 31;
	localparam int RAND_W    = 17;
	localparam int FUNC_W    = 2;
	localparam int PADDR_W   = 4;

	// Fixed point limits and constants
	localparam logic signed [31:0] INT_MAX   = 32'sh7fffffff;
	localparam logic signed [31:0] INT_MIN   = 32'sh80000000;
	localparam logic [RAND_W-1:0]  RAND_ONE  = 17'd65536;
	localparam logic signed [31:0] FRAC_ONE  = 32'sd65536;

	// Register reset values
	localparam logic signed [31:0] INERTIA_RST   = 32'sd65536;
	localparam logic signed [31:0] COGNITIVE_RST = 32'sd131072;
	localparam logic signed [31:0] SOCIAL_RST    = 32'sd131072;

	// Register indexes (word address)
	localparam logic [1:0] REG_INERTIA   = 2'd0;
	localparam logic [1:0] REG_COGNITIVE = 2'd1;
	localparam logic [1:0] REG_SOCIAL    = 2'd2;

	// Item operations
	typedef enum logic [FUNC_W-1:0] {
		FUNC_LOAD    = 2'd0,
		FUNC_INIT    = 2'd1,
		FUNC_MOVE    = 2'd2,
		FUNC_CAPTURE = 2'd3
	} func_t;

	// Request to the shared multiplier; frac selects FRAC_BITS, else a 16 bit shift
	typedef struct packed {
		logic signed [31:0] a;
		logic signed [31:0] b;
		logic               frac;
	} mul_req_t;

	// Saturate a wide signed value to 32 bits
	function automatic logic signed [31:0] sat32(input logic signed [63:0] x);
		logic signed [31:0] r;
		if (x > 64'(INT_MAX)) begin
			r = INT_MAX;
		end else if (x < 64'(INT_MIN)) begin
			r = INT_MIN;
		end else begin
			r = x[31:0];
		end
		return r;
	endfunction

endpackage

>>> design/pso_if.sv
// Item channels of the particle swarm update block: command in, result out.
interface pso_cmd_if;
	logic                                 valid;
	logic                                 ready;
	logic [pso_pkg::FUNC_W-1:0]           func;
	logic [pso_pkg::DIM_W-1:0]            dim;
	logic signed [pso_pkg::VAL_W-1:0]     pos_value;
	logic signed [pso_pkg::VAL_W-1:0]     low_bound;
	logic signed [pso_pkg::VAL_W-1:0]     high_bound;
	logic [pso_pkg::LIMIT_W-1:0]          speed_limit;
	logic signed [pso_pkg::VAL_W-1:0]     global_best;
	logic [pso_pkg::RAND_W-1:0]           rand_a;
	logic [pso_pkg::RAND_W-1:0]           rand_b;
	logic signed [pso_pkg::VAL_W-1:0]     fitness_in;

	modport source (
		output valid, func, dim, pos_value, low_bound, high_bound, speed_limit,
		       global_best, rand_a, rand_b, fitness_in,
		input  ready
	);
	modport sink (
		input  valid, func, dim, pos_value, low_bound, high_bound, speed_limit,
		       global_best, rand_a, rand_b, fitness_in,
		output ready
	);
endinterface

interface pso_rsp_if;
	logic                                 valid;
	logic                                 ready;
	logic [pso_pkg::DIM_W-1:0]            dim_out;
	logic signed [pso_pkg::VAL_W-1:0]     position_out;
	logic signed [pso_pkg::VAL_W-1:0]     velocity_out;
	logic                                 in_range;
	logic                                 all_in_range;
	logic signed [pso_pkg::VAL_W-1:0]     best_fitness;

	modport source (
		output valid, dim_out, position_out, velocity_out, in_range, all_in_range,
		       best_fitness,
		input  ready
	);
	modport sink (
		input  valid, dim_out, position_out, velocity_out, in_range, all_in_range,
		       best_fitness,
		output ready
	);
endinterface

>>> design/pso_ram.sv
// Generic single-port-write, registered-read RAM.
module pso_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 32
) (
	input  logic                                   clk,
	input  logic                                   we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                       wdata,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                       rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// Write port and registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

>>> design/pso_mul_unit.sv
// Shared signed 32x32 multiplier with floor shift and 32 bit saturation.
module pso_mul_unit (
	input  logic              clk,
	input  pso_pkg::mul_req_t req,
	output logic signed [31:0] res
);

	logic signed [63:0] prod_s1;
	logic               frac_s1;
	logic signed [63:0] shifted;

	// Register the exact product
	always_ff @(posedge clk) begin
		prod_s1 <= 64'(req.a) * 64'(req.b);
		frac_s1 <= req.frac;
	end

	// Arithmetic shift floors; then clip to 32 bits
	always_comb begin
		if (frac_s1) begin
			shifted = prod_s1 >>> pso_pkg::FRAC_BITS;
		end else begin
			shifted = prod_s1 >>> pso_pkg::RFRAC_BITS;
		end
		res = pso_pkg::sat32(shifted);
	end

endmodule

>>> design/pso_particle_update_unit.sv
// Particle swarm update block: one dimension per item, shared multiplier under a sequencer.
//
// Each command item works on one dimension of one particle in signed Q16.16 and yields
// exactly one result item. The block takes one item at a time, and a move item runs longest,
// since the single 32x32 multiplier is issued once a cycle: a move needs five chained
// products (c1*r1, c2*r2, w*v, k1*(pbest-pos), k2*(gbest-pos)) followed by three add and
// compare steps for the velocity clamp and the wall reflection; a read step ahead of them
// reads the per-dimension tables. The result goes into an output register, so the next
// item is taken while a result still waits; an item finishes only once that register is
// free. The six per-dimension tables sit in RAMs that are undefined after reset and need no
// clearing pass; each entry must be loaded or initialised before use. The weights w, c1 and
// c2 are written over the APB port at byte addresses 0, 4 and 8; the user must write them
// only while the block is idle, as the block itself does not enforce this.
module pso_particle_update_unit (
	input  logic                        clk,
	input  logic                        arst_n,
	pso_cmd_if.sink                     cmd,
	pso_rsp_if.source                   rsp,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [pso_pkg::PADDR_W-1:0] paddr,
	input  logic [31:0]                 pwdata,
	output logic [31:0]                 prdata,
	output logic                        pready
);

	typedef enum logic [8:0] {
		S_IDLE    = 9'b000000001,
		S_READ    = 9'b000000010,
		S_PREP    = 9'b000000100,
		S_INIT_V  = 9'b000001000,
		S_MUL     = 9'b000010000,
		S_VCLAMP  = 9'b000100000,
		S_REFL_HI = 9'b001000000,
		S_REFL_LO = 9'b010000000,
		S_FINISH  = 9'b100000000
	} state_t;

	// Multiplier steps of a move
	localparam logic [2:0] STEP_K1 = 3'd0;
	localparam logic [2:0] STEP_K2 = 3'd1;
	localparam logic [2:0] STEP_T0 = 3'd2;
	localparam logic [2:0] STEP_T1 = 3'd3;
	localparam logic [2:0] STEP_T2 = 3'd4;

	state_t state_q, state_d;
	logic [2:0] step_q;

	// Configuration registers
	logic signed [31:0] inertia_q, cognitive_q, social_q;

	// Latched item
	pso_pkg::func_t                 func_q;
	logic [pso_pkg::DIM_W-1:0]      dim_q;
	logic [pso_pkg::ADDR_W-1:0]     addr_q;
	logic                           dim_ok_q;
	logic signed [31:0]             pos_value_q, low_q, high_q, gbest_q, fitness_q;
	logic [pso_pkg::LIMIT_W-1:0]    limit_q;
	logic [pso_pkg::RAND_W-1:0]     r1_q, r2_q;

	// Working registers
	logic signed [31:0] k1_q, k2_q, d1_q, d2_q;
	logic signed [33:0] acc_q;
	logic signed [34:0] np_q;
	logic signed [31:0] res_pos_q, res_vel_q;

	// Persistent state
	logic signed [31:0] best_score_q;
	logic               accum_q;

	// Output register
	logic                      rsp_valid_q;
	logic [pso_pkg::DIM_W-1:0] rsp_dim_q;
	logic signed [31:0]        rsp_pos_q, rsp_vel_q, rsp_best_q;
	logic                      rsp_inr_q, rsp_all_q;

	// Table read data
	logic [31:0] pos_rdata, vel_rdata, best_rdata, lo_rdata, hi_rdata, lim_rdata;
	logic signed [31:0] pos_rd, vel_rd, best_rd, lo_rd, hi_rd, lim_rd;

	logic cmd_acc, out_free, fin_go;
	logic we_pos, we_vel, we_best, we_bnd;
	logic cfg_we;

	pso_pkg::mul_req_t  mul_req;
	logic signed [31:0] mul_res;

	logic [pso_pkg::RAND_W-1:0] r1_sat, r2_sat;
	logic signed [31:0] init_a, init_pos;
	logic signed [31:0] vsat;
	logic signed [32:0] vclip1, vclip2, neg_lim;
	logic signed [34:0] np_sum, np_refl;
	logic signed [35:0] np_lo;
	logic signed [31:0] fin_lo, fin_hi;
	logic               fin_inr, fin_all;

	assign pos_rd  = $signed(pos_rdata);
	assign vel_rd  = $signed(vel_rdata);
	assign best_rd = $signed(best_rdata);
	assign lo_rd   = $signed(lo_rdata);
	assign hi_rd   = $signed(hi_rdata);
	assign lim_rd  = $signed(lim_rdata);

	// Handshakes
	assign cmd.ready = (state_q == S_IDLE);
	assign cmd_acc   = cmd.valid && cmd.ready;
	assign out_free  = !rsp_valid_q || rsp.ready;
	assign fin_go    = (state_q == S_FINISH) && out_free;

	// Fractions above one clip to one
	assign r1_sat = (cmd.rand_a > pso_pkg::RAND_ONE) ? pso_pkg::RAND_ONE : cmd.rand_a;
	assign r2_sat = (cmd.rand_b > pso_pkg::RAND_ONE) ? pso_pkg::RAND_ONE : cmd.rand_b;

	// APB register file
	assign pready = 1'b1;
	assign cfg_we = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inertia_q   <= pso_pkg::INERTIA_RST;
			cognitive_q <= pso_pkg::COGNITIVE_RST;
			social_q    <= pso_pkg::SOCIAL_RST;
		end else if (cfg_we) begin
			unique case (paddr[3:2])
				pso_pkg::REG_INERTIA:   inertia_q   <= $signed(pwdata);
				pso_pkg::REG_COGNITIVE: cognitive_q <= $signed(pwdata);
				pso_pkg::REG_SOCIAL:    social_q    <= $signed(pwdata);
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[3:2])
			pso_pkg::REG_INERTIA:   prdata = inertia_q;
			pso_pkg::REG_COGNITIVE: prdata = cognitive_q;
			pso_pkg::REG_SOCIAL:    prdata = social_q;
			default:                prdata = '0;
		endcase
	end

	// Sequencer
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (cmd_acc) state_d = S_READ;
			end
			S_READ: state_d = S_PREP;
			S_PREP: begin
				if (!dim_ok_q) begin
					state_d = S_FINISH;
				end else begin
					unique case (func_q)
						pso_pkg::FUNC_INIT: state_d = S_INIT_V;
						pso_pkg::FUNC_MOVE: state_d = S_MUL;
						default:            state_d = S_FINISH;
					endcase
				end
			end
			S_INIT_V: state_d = S_FINISH;
			S_MUL: begin
				if (step_q == STEP_T2) state_d = S_VCLAMP;
			end
			S_VCLAMP:  state_d = S_REFL_HI;
			S_REFL_HI: state_d = S_REFL_LO;
			S_REFL_LO: state_d = S_FINISH;
			S_FINISH: begin
				if (out_free) state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			step_q  <= STEP_K1;
		end else begin
			state_q <= state_d;
			if (state_q == S_PREP) begin
				step_q <= STEP_K1;
			end else if (state_q == S_MUL) begin
				step_q <= step_q + 3'd1;
			end
		end
	end

	// Operand select for the shared multiplier
	assign init_a = $signed(32'({r1_q, 1'b0})) - pso_pkg::FRAC_ONE;

	always_comb begin
		mul_req.a    = cognitive_q;
		mul_req.b    = $signed(32'(r1_q));
		mul_req.frac = 1'b0;
		unique case (state_q)
			S_PREP: begin
				if (func_q == pso_pkg::FUNC_INIT) begin
					mul_req.a = init_a;
					mul_req.b = lim_rd;
				end
			end
			S_MUL: begin
				unique case (step_q)
					STEP_K1: begin
						mul_req.a = social_q;
						mul_req.b = $signed(32'(r2_q));
					end
					STEP_K2: begin
						mul_req.a    = inertia_q;
						mul_req.b    = vel_rd;
						mul_req.frac = 1'b1;
					end
					STEP_T0: begin
						mul_req.a    = k1_q;
						mul_req.b    = d1_q;
						mul_req.frac = 1'b1;
					end
					STEP_T1: begin
						mul_req.a    = k2_q;
						mul_req.b    = d2_q;
						mul_req.frac = 1'b1;
					end
					default: ;
				endcase
			end
			default: ;
		endcase
	end

	pso_mul_unit u_mul (
		.clk (clk),
		.req (mul_req),
		.res (mul_res)
	);

	// Clamp the start position, low bound tested first
	always_comb begin
		if (pos_value_q < lo_rd) begin
			init_pos = lo_rd;
		end else if (pos_value_q > hi_rd) begin
			init_pos = hi_rd;
		end else begin
			init_pos = pos_value_q;
		end
	end

	// Saturate the velocity sum, then clamp to the speed limit
	always_comb begin
		vsat    = pso_pkg::sat32(64'(acc_q));
		neg_lim = -33'(lim_rd);
		vclip1  = (33'(vsat) > 33'(lim_rd)) ? 33'(lim_rd) : 33'(vsat);
		vclip2  = (vclip1 < neg_lim) ? neg_lim : vclip1;
	end

	// Reflection at the walls, high wall first
	always_comb begin
		np_sum  = 35'(pos_rd) + 35'(res_vel_q);
		np_refl = (np_sum > 35'(hi_rd)) ? ((35'(hi_rd) <<< 1) - np_sum) : np_sum;
		np_lo   = (36'(np_q) < 36'(lo_rd)) ? ((36'(lo_rd) <<< 1) - 36'(np_q)) : 36'(np_q);
	end

	// Final range test and running AND
	always_comb begin
		fin_lo  = (func_q == pso_pkg::FUNC_LOAD) ? low_q  : lo_rd;
		fin_hi  = (func_q == pso_pkg::FUNC_LOAD) ? high_q : hi_rd;
		fin_inr = dim_ok_q && (res_pos_q >= fin_lo) && (res_pos_q <= fin_hi);
		if (!dim_ok_q) begin
			fin_all = accum_q;
		end else if (dim_q == '0) begin
			fin_all = fin_inr;
		end else begin
			fin_all = accum_q && fin_inr;
		end
	end

	// Latch the item and work the datapath
	always_ff @(posedge clk) begin
		if (cmd_acc) begin
			func_q      <= pso_pkg::func_t'(cmd.func);
			dim_q       <= cmd.dim;
			addr_q      <= pso_pkg::ADDR_W'(cmd.dim);
			dim_ok_q    <= (32'(cmd.dim) < 32'(pso_pkg::DIMS));
			pos_value_q <= cmd.pos_value;
			low_q       <= cmd.low_bound;
			high_q      <= cmd.high_bound;
			limit_q     <= cmd.speed_limit;
			gbest_q     <= cmd.global_best;
			r1_q        <= r1_sat;
			r2_q        <= r2_sat;
			fitness_q   <= cmd.fitness_in;
		end
		if (state_q == S_PREP) begin
			d1_q <= pso_pkg::sat32(64'(best_rd) - 64'(pos_rd));
			d2_q <= pso_pkg::sat32(64'(gbest_q) - 64'(pos_rd));
			if (func_q == pso_pkg::FUNC_INIT) begin
				res_pos_q <= init_pos;
			end else begin
				res_pos_q <= pos_rd;
				res_vel_q <= vel_rd;
			end
		end
		if (state_q == S_INIT_V) begin
			res_vel_q <= mul_res;
		end
		if (state_q == S_MUL) begin
			unique case (step_q)
				STEP_K1: k1_q  <= mul_res;
				STEP_K2: k2_q  <= mul_res;
				STEP_T0: acc_q <= 34'(mul_res);
				default: acc_q <= acc_q + 34'(mul_res);
			endcase
		end
		if (state_q == S_VCLAMP) begin
			res_vel_q <= vclip2[31:0];
		end
		if (state_q == S_REFL_HI) begin
			np_q <= np_refl;
		end
		if (state_q == S_REFL_LO) begin
			res_pos_q <= pso_pkg::sat32(64'(np_lo));
		end
		if (fin_go) begin
			rsp_dim_q  <= dim_q;
			rsp_pos_q  <= dim_ok_q ? res_pos_q : '0;
			rsp_vel_q  <= dim_ok_q ? res_vel_q : '0;
			rsp_inr_q  <= fin_inr;
			rsp_all_q  <= fin_all;
			if (!dim_ok_q) begin
				rsp_best_q <= best_score_q;
			end else if (func_q == pso_pkg::FUNC_INIT) begin
				rsp_best_q <= pso_pkg::INT_MIN;
			end else if (func_q == pso_pkg::FUNC_CAPTURE) begin
				rsp_best_q <= fitness_q;
			end else begin
				rsp_best_q <= best_score_q;
			end
		end
	end

	// Persistent fitness, running AND and result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			best_score_q <= pso_pkg::INT_MIN;
			accum_q      <= 1'b1;
			rsp_valid_q  <= 1'b0;
		end else begin
			if (fin_go) begin
				accum_q     <= fin_all;
				rsp_valid_q <= 1'b1;
				if (dim_ok_q && func_q == pso_pkg::FUNC_INIT) begin
					best_score_q <= pso_pkg::INT_MIN;
				end else if (dim_ok_q && func_q == pso_pkg::FUNC_CAPTURE) begin
					best_score_q <= fitness_q;
				end
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	assign rsp.valid        = rsp_valid_q;
	assign rsp.dim_out      = rsp_dim_q;
	assign rsp.position_out = rsp_pos_q;
	assign rsp.velocity_out = rsp_vel_q;
	assign rsp.in_range     = rsp_inr_q;
	assign rsp.all_in_range = rsp_all_q;
	assign rsp.best_fitness = rsp_best_q;

	// Table writes, committed as the item finishes
	assign we_pos  = fin_go && dim_ok_q &&
	                 (func_q == pso_pkg::FUNC_INIT || func_q == pso_pkg::FUNC_MOVE);
	assign we_vel  = we_pos;
	assign we_best = fin_go && dim_ok_q &&
	                 (func_q == pso_pkg::FUNC_INIT || func_q == pso_pkg::FUNC_CAPTURE);
	assign we_bnd  = fin_go && dim_ok_q && (func_q == pso_pkg::FUNC_LOAD);

	pso_ram #(.WIDTH(32), .DEPTH(pso_pkg::DIMS)) u_pos_ram (
		.clk (clk), .we (we_pos), .waddr (addr_q), .wdata (res_pos_q),
		.raddr (addr_q), .rdata (pos_rdata)
	);

	pso_ram #(.WIDTH(32), .DEPTH(pso_pkg::DIMS)) u_vel_ram (
		.clk (clk), .we (we_vel), .waddr (addr_q), .wdata (res_vel_q),
		.raddr (addr_q), .rdata (vel_rdata)
	);

	pso_ram #(.WIDTH(32), .DEPTH(pso_pkg::DIMS)) u_best_ram (
		.clk (clk), .we (we_best), .waddr (addr_q), .wdata (res_pos_q),
		.raddr (addr_q), .rdata (best_rdata)
	);

	pso_ram #(.WIDTH(32), .DEPTH(pso_pkg::DIMS)) u_lo_ram (
		.clk (clk), .we (we_bnd), .waddr (addr_q), .wdata (low_q),
		.raddr (addr_q), .rdata (lo_rdata)
	);

	pso_ram #(.WIDTH(32), .DEPTH(pso_pkg::DIMS)) u_hi_ram (
		.clk (clk), .we (we_bnd), .waddr (addr_q), .wdata (high_q),
		.raddr (addr_q), .rdata (hi_rdata)
	);

	pso_ram #(.WIDTH(32), .DEPTH(pso_pkg::DIMS)) u_lim_ram (
		.clk (clk), .we (we_bnd), .waddr (addr_q), .wdata (32'(limit_q)),
		.raddr (addr_q), .rdata (lim_rdata)
	);

`ifndef NO_ASSERTIONS
	// An accepted item starts with the table read
	a_accept_reads: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.valid && cmd.ready) |=> (state_q == S_READ))
		else $error("accepted item did not start the table read");

	// A move enters the multiplier sequence at its first step
	a_move_starts: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_PREP && func_q == pso_pkg::FUNC_MOVE && dim_ok_q) |=>
		(state_q == S_MUL && step_q == STEP_K1))
		else $error("move did not start the multiplier sequence");

	// The multiplier sequence never runs past its last step
	a_step_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_MUL) |-> (step_q <= STEP_T2))
		else $error("multiplier step out of range");

	// A finished item waits while the output register is still full
	a_hold_finish: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_FINISH && rsp_valid_q && !rsp.ready) |=>
		(state_q == S_FINISH && rsp_valid_q))
		else $error("item finished over an untaken result");
`endif

endmodule
